// ===== sv/rhsm_pkg.sv =====
// Shared types, constants and modular helpers of the rolling hash matcher.
`default_nettype none
package rhsm_pkg;

   localparam int HASH_W = 61;
   localparam int HALF_W = 32;
   localparam int BYTE_W = 8;
   localparam int START_W = 16;

   typedef logic [HASH_W-1:0] hash_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam hash_type MERSENNE_P = {HASH_W{1'b1}};
   localparam hash_type BASE_RESET = 61'd257;

   // register file: one 64-bit register per 8 bytes
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_BIT = 3;
   localparam logic CSR_IDX_HASH_BASE = 1'b0;

   // multiplier operand selects
   localparam logic [1:0] MS_PH = 2'd0;
   localparam logic [1:0] MS_LP = 2'd1;
   localparam logic [1:0] MS_LEAVE = 2'd2;
   localparam logic [1:0] MS_HB = 2'd3;

   typedef struct packed {
      logic       load_in;
      logic       clear_step;
      logic       pat_write;
      logic       set_ovf;
      logic       leave_read;
      logic       h_from_wh;
      logic       h_from_sub;
      logic       mul_start;
      logic [1:0] mul_sel;
      logic       ph_update;
      logic       lp_update;
      logic       len_inc;
      logic       txt_update;
      logic       verify_init;
      logic       verify_next;
      logic       emit;
      logic       emit_found;
   } dp_cmd_type;

   typedef struct packed {
      logic func;
      logic len_nonzero;
      logic pat_full;
      logic txt_full;
      logic leave_needed;
      logic hit;
      logic mul_done;
      logic byte_eq;
      logic last_cmp;
      logic out_free;
   } dp_sts_type;

   function automatic hash_type addmod(input hash_type a, input hash_type b);
      logic [HASH_W:0] s;
      logic [HASH_W:0] d;
      s = {1'b0, a} + {1'b0, b};
      d = s - {1'b0, MERSENNE_P};
      return (s >= {1'b0, MERSENNE_P}) ? d[HASH_W-1:0] : s[HASH_W-1:0];
   endfunction

   function automatic hash_type submod(input hash_type a, input hash_type b);
      logic [HASH_W:0] s;
      s = {1'b0, a} + {1'b0, MERSENNE_P} - {1'b0, b};
      return (a >= b) ? (a - b) : s[HASH_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/rhsm_ifs.sv =====
// Request and response channel interfaces.
`default_nettype none
interface rhsm_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] byte_value;
   logic       first;
   modport source (output valid, func, byte_value, first, input ready);
   modport sink (input valid, func, byte_value, first, output ready);
endinterface

interface rhsm_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [15:0] match_start;
   logic        overflow;
   modport source (output valid, found, match_start, overflow, input ready);
   modport sink (input valid, found, match_start, overflow, output ready);
endinterface
`default_nettype wire

// ===== sv/rolling_hash_string_matcher.sv =====
// Top level: Rabin-Karp matcher with APB register port.
//
//  channel   direction  handshake       payload
//  req_bus   in         valid/ready     func, byte_value, first
//  rsp_bus   out        valid/ready     found, match_start, overflow
//  csr_*     in/out     APB psel/pen    hash_base at byte address 0 (64-bit)
//
// Pattern byte: two multiplies, hash step then base power; the first byte needs only the hash step.
// Text byte: a leave multiply once the window is full, then the roll multiply; leave and roll share
// the one 32x32 multiplier, and a hash hit adds a read and a compare per pattern byte verified.
// Reset is synchronous; no clearing pass.
// A stalled response holds the sequencer before the next result is written;
// the next request is taken while a result still waits in the output register.
`default_nettype none
module rolling_hash_string_matcher #(
   parameter int MAX_PAT = 64,
   parameter int MAX_TEXT = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   rhsm_req_if.sink                          req_bus,
   rhsm_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rhsm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rhsm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rhsm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import rhsm_pkg::*;

   hash_type   hash_base_ff, hash_base_in;
   hash_type   base_eff;
   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       csr_hit;

   always_comb begin
      csr_hit = (csr_paddr[CSR_IDX_BIT] == CSR_IDX_HASH_BASE);
      hash_base_in = hash_base_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         hash_base_in = csr_pwdata[HASH_W-1:0];
      end
      csr_prdata = csr_hit ? CSR_DATA_W'(hash_base_ff) : '0;
      // an all-ones base is P itself and means zero
      base_eff = (hash_base_ff == MERSENNE_P) ? '0 : hash_base_ff;
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) hash_base_ff <= BASE_RESET;
      else hash_base_ff <= hash_base_in;
   end

   rhsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rhsm_datapath #(
      .MAX_PAT  (MAX_PAT),
      .MAX_TEXT (MAX_TEXT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .base         (base_eff),
      .in_func      (req_bus.func),
      .in_byte      (req_bus.byte_value),
      .in_first     (req_bus.first),
      .out_valid    (rsp_bus.valid),
      .out_ready    (rsp_bus.ready),
      .out_found    (rsp_bus.found),
      .out_start    (rsp_bus.match_start),
      .out_overflow (rsp_bus.overflow)
   );

endmodule
`default_nettype wire

// ===== sv/rhsm_mulmod.sv =====
// Multi-cycle 61x61 multiply modulo 2^61-1 on one 32x32 multiplier.
`default_nettype none
module rhsm_mulmod (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  rhsm_pkg::hash_type op_a,
   input  rhsm_pkg::hash_type op_b,
   output logic               done,
   output rhsm_pkg::hash_type result
);
   import rhsm_pkg::*;

   localparam int ACC_W = 2 * HASH_W;
   localparam int HI_W = HASH_W - HALF_W;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [2:0]            step_ff, step_in;
   hash_type              a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic [2*HALF_W-1:0]   prod_ff, prod_in;
   logic [1:0]            sh_ff, sh_in;
   logic [ACC_W-1:0]      acc_ff, acc_in, acc_add;
   logic [HASH_W:0]       fold_ff, fold_in;
   logic [HALF_W-1:0]     mx, my;
   logic [HASH_W:0]       g, gsub;

   always_comb begin
      mx = step_ff[1] ? {{(HALF_W-HI_W){1'b0}}, a_ff[HASH_W-1:HALF_W]} : a_ff[HALF_W-1:0];
      my = step_ff[0] ? {{(HALF_W-HI_W){1'b0}}, b_ff[HASH_W-1:HALF_W]} : b_ff[HALF_W-1:0];
      case (sh_ff)
         2'd0: acc_add = ACC_W'(prod_ff);
         2'd1: acc_add = ACC_W'({prod_ff, {HALF_W{1'b0}}});
         default: acc_add = ACC_W'({prod_ff, {(2*HALF_W){1'b0}}});
      endcase
      // 2^61 == 1 mod P, so the carry bit folds back in as one
      g = {1'b0, fold_ff[HASH_W-1:0]} + {{HASH_W{1'b0}}, fold_ff[HASH_W]};
      gsub = g - {1'b0, MERSENNE_P};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in = a_ff;
      b_in = b_ff;
      res_in = res_ff;
      prod_in = prod_ff;
      sh_in = sh_ff;
      acc_in = acc_ff;
      fold_in = fold_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         a_in = op_a;
         b_in = op_b;
         acc_in = '0;
         prod_in = '0;
         sh_in = 2'd0;
      end else if (busy_ff) begin
         case (step_ff)
            3'd0, 3'd1, 3'd2, 3'd3: begin
               acc_in = acc_ff + acc_add;
               prod_in = mx * my;
               sh_in = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
               step_in = step_ff + 3'd1;
            end
            3'd4: begin
               acc_in = acc_ff + acc_add;
               step_in = step_ff + 3'd1;
            end
            3'd5: begin
               fold_in = {1'b0, acc_ff[ACC_W-1:HASH_W]} + {1'b0, acc_ff[HASH_W-1:0]};
               step_in = step_ff + 3'd1;
            end
            default: begin
               res_in = (g >= {1'b0, MERSENNE_P}) ? gsub[HASH_W-1:0] : g[HASH_W-1:0];
               done_in = 1'b1;
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      res_ff <= res_in;
      prod_ff <= prod_in;
      sh_ff <= sh_in;
      acc_ff <= acc_in;
      fold_ff <= fold_in;
   end

   assign done = done_ff;
   assign result = res_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("multiply started while busy");
   a_canonical: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (res_ff != MERSENNE_P)) else $error("multiply result not reduced");

endmodule
`default_nettype wire

// ===== sv/rhsm_datapath.sv =====
// Datapath: hash state, pattern and text stores, verify pointers, result register.
`default_nettype none
module rhsm_datapath #(
   parameter int MAX_PAT = 64,
   parameter int MAX_TEXT = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rhsm_pkg::dp_cmd_type  cmd,
   output rhsm_pkg::dp_sts_type  sts,
   input  rhsm_pkg::hash_type    base,
   input  logic                  in_func,
   input  rhsm_pkg::byte_type    in_byte,
   input  logic                  in_first,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_found,
   output logic [15:0]           out_start,
   output logic                  out_overflow
);
   import rhsm_pkg::*;

   localparam int PTR_W = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
   localparam int LEN_W = $clog2(MAX_PAT + 1);
   localparam int CNT_W = $clog2(MAX_TEXT + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAT);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_PAT - 1);
   localparam logic [LEN_W:0]   RING = (LEN_W + 1)'(MAX_PAT);

   logic                func_ff, first_ff;
   byte_type            byte_ff;
   logic [LEN_W-1:0]    len_ff, len_in;
   hash_type            ph_ff, ph_in, lp_ff, lp_in, wh_ff, wh_in, h_ff, h_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, vr_ptr_ff, vr_ptr_in;
   logic [LEN_W-1:0]    vj_ff, vj_in;
   logic                ovf_ff, ovf_in;
   byte_type            pat_rd_ff, rec_rd_ff;
   logic [PTR_W-1:0]    rec_raddr;
   byte_type            pat_mem [MAX_PAT];
   byte_type            rec_mem [MAX_PAT];

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff;
   logic [15:0]         rsp_start_ff;
   logic                rsp_ovf_ff;

   logic                mul_start, mul_done;
   hash_type            mul_a, mul_b, mul_res;
   hash_type            byte_h;
   logic [LEN_W:0]      ring_sum, ring_back;
   logic [CMP_W-1:0]    cnt_x, len_x, start_x;
   logic [CMP_W+15:0]   start_ext;
   logic [PTR_W-1:0]    wr_next, vr_next;

   rhsm_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   always_comb begin
      byte_h = {{(HASH_W-BYTE_W){1'b0}}, byte_ff};
      cnt_x = CMP_W'(cnt_ff);
      len_x = CMP_W'(len_ff);
      start_x = cnt_x - len_x;
      start_ext = {16'b0, start_x};
      // ring position m bytes back from the write pointer
      ring_sum = {{(LEN_W+1-PTR_W){1'b0}}, wr_ptr_ff} + RING - {1'b0, len_ff};
      ring_back = (ring_sum >= RING) ? (ring_sum - RING) : ring_sum;
      wr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      vr_next = (vr_ptr_ff == PTR_LAST) ? '0 : vr_ptr_ff + 1'b1;
      rec_raddr = cmd.leave_read ? ring_back[PTR_W-1:0] : vr_ptr_ff;

      mul_start = cmd.mul_start;
      case (cmd.mul_sel)
         MS_PH: begin
            mul_a = ph_ff;
            mul_b = base;
         end
         MS_LP: begin
            mul_a = lp_ff;
            mul_b = base;
         end
         MS_LEAVE: begin
            mul_a = {{(HASH_W-BYTE_W){1'b0}}, rec_rd_ff};
            mul_b = lp_ff;
         end
         default: begin
            mul_a = h_ff;
            mul_b = base;
         end
      endcase

      len_in = len_ff;
      ph_in = ph_ff;
      lp_in = lp_ff;
      wh_in = wh_ff;
      h_in = h_ff;
      cnt_in = cnt_ff;
      wr_ptr_in = wr_ptr_ff;
      vr_ptr_in = vr_ptr_ff;
      vj_in = vj_ff;
      ovf_in = ovf_ff;

      if (cmd.clear_step) begin
         if (!func_ff && first_ff) begin
            len_in = '0;
            ph_in = '0;
            lp_in = hash_type'(1);
            ovf_in = 1'b0;
         end
         if (!func_ff || first_ff) begin
            cnt_in = '0;
            wh_in = '0;
            wr_ptr_in = '0;
         end
      end
      if (cmd.set_ovf) ovf_in = 1'b1;
      if (cmd.h_from_wh) h_in = wh_ff;
      if (cmd.h_from_sub) h_in = submod(wh_ff, mul_res);
      if (cmd.ph_update) ph_in = addmod(mul_res, byte_h);
      if (cmd.lp_update) lp_in = mul_res;
      if (cmd.len_inc) len_in = len_ff + 1'b1;
      if (cmd.txt_update) begin
         wh_in = addmod(mul_res, byte_h);
         cnt_in = cnt_ff + 1'b1;
         wr_ptr_in = wr_next;
      end
      if (cmd.verify_init) begin
         vr_ptr_in = ring_back[PTR_W-1:0];
         vj_in = '0;
      end
      if (cmd.verify_next) begin
         vr_ptr_in = vr_next;
         vj_in = vj_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (out_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ph_ff <= '0;
         lp_ff <= hash_type'(1);
         wh_ff <= '0;
         cnt_ff <= '0;
         wr_ptr_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ph_ff <= ph_in;
         lp_ff <= lp_in;
         wh_ff <= wh_in;
         cnt_ff <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         func_ff <= in_func;
         byte_ff <= in_byte;
         first_ff <= in_first;
      end
      h_ff <= h_in;
      vr_ptr_ff <= vr_ptr_in;
      vj_ff <= vj_in;
      if (cmd.emit) begin
         rsp_found_ff <= cmd.emit_found;
         rsp_start_ff <= cmd.emit_found ? start_ext[15:0] : 16'd0;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   // pattern store and text ring
   always_ff @(posedge clock) begin
      if (cmd.pat_write) pat_mem[len_ff[PTR_W-1:0]] <= byte_ff;
      pat_rd_ff <= pat_mem[vj_ff[PTR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.txt_update) rec_mem[wr_ptr_ff] <= byte_ff;
      rec_rd_ff <= rec_mem[rec_raddr];
   end

   always_comb begin
      sts.func = func_ff;
      sts.len_nonzero = (len_ff != '0);
      sts.pat_full = (len_ff == LEN_MAX);
      sts.txt_full = (cnt_ff == CNT_MAX);
      sts.leave_needed = (len_ff != '0) && (cnt_x >= len_x);
      sts.hit = (len_ff != '0) && (cnt_x >= len_x) && (wh_ff == ph_ff);
      sts.mul_done = mul_done;
      sts.byte_eq = (pat_rd_ff == rec_rd_ff);
      sts.last_cmp = ((vj_ff + 1'b1) == len_ff);
      sts.out_free = !rsp_valid_ff || out_ready;
   end

   assign out_valid = rsp_valid_ff;
   assign out_found = rsp_found_ff;
   assign out_start = rsp_start_ff;
   assign out_overflow = rsp_ovf_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX) else $error("pattern length past store size");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.txt_update |-> (cnt_ff != CNT_MAX)) else $error("text byte taken past limit");
   a_pat_room: assert property (@(posedge clock) disable iff (reset)
      cmd.pat_write |-> (len_ff != LEN_MAX)) else $error("pattern write into full store");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || out_ready)) else $error("result overwritten");

endmodule
`default_nettype wire

// ===== sv/rhsm_ctrl.sv =====
// Sequencer: steps one request through hashing, rolling and byte verification.
`default_nettype none
module rhsm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rhsm_pkg::dp_sts_type sts,
   output rhsm_pkg::dp_cmd_type cmd
);
   import rhsm_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_CHECK  = 4'd2;
   localparam logic [3:0] S_PH_MUL = 4'd3;
   localparam logic [3:0] S_LP_MUL = 4'd4;
   localparam logic [3:0] S_LV_RD  = 4'd5;
   localparam logic [3:0] S_LV_MUL = 4'd6;
   localparam logic [3:0] S_HB     = 4'd7;
   localparam logic [3:0] S_HB_MUL = 4'd8;
   localparam logic [3:0] S_HIT    = 4'd9;
   localparam logic [3:0] S_V_RD   = 4'd10;
   localparam logic [3:0] S_V_CMP  = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       found_ff, found_in;

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      cmd = '0;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.func) begin
               if (sts.pat_full) begin
                  cmd.set_ovf = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.pat_write = 1'b1;
                  cmd.mul_start = 1'b1;
                  cmd.mul_sel = MS_PH;
                  state_in = S_PH_MUL;
               end
            end else if (sts.txt_full) begin
               cmd.set_ovf = 1'b1;
               found_in = 1'b0;
               state_in = S_OUT;
            end else if (sts.leave_needed) begin
               cmd.leave_read = 1'b1;
               state_in = S_LV_RD;
            end else begin
               cmd.h_from_wh = 1'b1;
               state_in = S_HB;
            end
         end
         S_PH_MUL: begin
            if (sts.mul_done) begin
               cmd.ph_update = 1'b1;
               cmd.len_inc = 1'b1;
               // base^(m-1): no step for the first pattern byte
               if (sts.len_nonzero) begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_sel = MS_LP;
                  state_in = S_LP_MUL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_LP_MUL: begin
            if (sts.mul_done) begin
               cmd.lp_update = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LV_RD: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel = MS_LEAVE;
            state_in = S_LV_MUL;
         end
         S_LV_MUL: begin
            if (sts.mul_done) begin
               cmd.h_from_sub = 1'b1;
               state_in = S_HB;
            end
         end
         S_HB: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel = MS_HB;
            state_in = S_HB_MUL;
         end
         S_HB_MUL: begin
            cmd.mul_sel = MS_HB;
            if (sts.mul_done) begin
               cmd.txt_update = 1'b1;
               state_in = S_HIT;
            end
         end
         S_HIT: begin
            if (sts.hit) begin
               cmd.verify_init = 1'b1;
               state_in = S_V_RD;
            end else begin
               found_in = 1'b0;
               state_in = S_OUT;
            end
         end
         S_V_RD: begin
            state_in = S_V_CMP;
         end
         S_V_CMP: begin
            if (!sts.byte_eq) begin
               found_in = 1'b0;
               state_in = S_OUT;
            end else if (sts.last_cmp) begin
               found_in = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.verify_next = 1'b1;
               state_in = S_V_RD;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.emit_found = found_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

   a_wait_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HB) |=> (state_ff == S_HB_MUL)) else $error("hash step skipped");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ph_update, cmd.lp_update, cmd.h_from_sub, cmd.txt_update}))
      else $error("multiplier result claimed twice");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the Rabin-Karp rolling hash string matcher.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import rhsm_pkg::*;

   localparam int PAT_DEPTH = 64;
   localparam int TEXT_LIMIT = 65536;
   localparam int RANDOM_REQUESTS = 850;
   localparam int DRAIN_CYCLES = 60;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam logic FUNC_PATTERN = 1'b0;
   localparam logic FUNC_TEXT = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] ADDR_HASH_BASE =
      CSR_ADDR_W'({CSR_IDX_HASH_BASE, 3'b000});

   typedef struct {
      logic        found;
      logic [15:0] start;
      logic        ovf;
   } match_result_type;

   typedef struct {
      logic     func;
      byte_type value;
      logic     first;
      bit       typed;
      logic     found;
      logic [15:0] start;
      logic     ovf;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   rhsm_req_if req_bus();
   rhsm_rsp_if rsp_bus();

   rolling_hash_string_matcher DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // matcher state mirror
   hash_type base_reg;
   byte_type pat_mem [PAT_DEPTH];
   byte_type text_ring [PAT_DEPTH];
   int       pat_len;
   hash_type pat_hash, win_hash, lead_pow;
   int       text_cnt;
   bit       ovf_flag;

   match_result_type pending_results[$];
   int  error_count = 0;
   longint cycle_count = 0;
   int  stall_mode = 0;
   int  stall_left = 0;
   int  request_count = 0;

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic hash_type mul_p(input hash_type a, input hash_type b);
      logic [121:0] prod;
      logic [63:0] r;
      prod = a * b;
      r = {3'b0, prod[121:61]} + {3'b0, prod[60:0]};
      r = {3'b0, r[60:0]} + {61'b0, r[63:61]};
      if (r >= {3'b0, MERSENNE_P}) r = r - {3'b0, MERSENNE_P};
      return r[60:0];
   endfunction

   function automatic hash_type add_p(input hash_type a, input hash_type b);
      logic [61:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MERSENNE_P}) s = s - {1'b0, MERSENNE_P};
      return s[60:0];
   endfunction

   function automatic hash_type sub_p(input hash_type a, input hash_type b);
      logic [61:0] s;
      s = {1'b0, a} + {1'b0, MERSENNE_P} - {1'b0, b};
      return (a >= b) ? a - b : s[60:0];
   endfunction

   function automatic void clear_mirror();
      base_reg = BASE_RESET;
      pat_len = 0; pat_hash = '0; lead_pow = 61'd1;
      text_cnt = 0; win_hash = '0; ovf_flag = 1'b0;
   endfunction

   // advances the mirror by one request; returns 1 when a result is due
   function automatic bit rabin_karp_step(input logic func, input byte_type value,
                                          input logic first,
                                          output match_result_type res);
      hash_type b, h;
      int s;
      bit same;
      b = (base_reg == MERSENNE_P) ? '0 : base_reg;
      res = '{found: 1'b0, start: 16'd0, ovf: 1'b0};
      if (func == FUNC_PATTERN) begin
         if (first) begin
            pat_len = 0; pat_hash = '0; lead_pow = 61'd1; ovf_flag = 1'b0;
         end
         text_cnt = 0; win_hash = '0;
         if (pat_len < PAT_DEPTH) begin
            pat_mem[pat_len] = value;
            pat_hash = add_p(mul_p(pat_hash, b), {53'b0, value});
            if (pat_len > 0) lead_pow = mul_p(lead_pow, b);
            pat_len++;
         end else begin
            ovf_flag = 1'b1;
         end
         return 1'b0;
      end
      if (first) begin
         text_cnt = 0; win_hash = '0;
      end
      if (text_cnt >= TEXT_LIMIT) begin
         ovf_flag = 1'b1;
      end else begin
         h = win_hash;
         if (pat_len > 0 && text_cnt >= pat_len)
            h = sub_p(h, mul_p({53'b0, text_ring[(text_cnt - pat_len) % PAT_DEPTH]},
                               lead_pow));
         win_hash = add_p(mul_p(h, b), {53'b0, value});
         text_ring[text_cnt % PAT_DEPTH] = value;
         text_cnt++;
         if (pat_len > 0 && text_cnt >= pat_len && win_hash == pat_hash) begin
            s = text_cnt - pat_len;
            same = 1'b1;
            for (int j = 0; j < pat_len; j++)
               if (text_ring[(s + j) % PAT_DEPTH] != pat_mem[j]) same = 1'b0;
            if (same) begin
               res.found = 1'b1;
               res.start = s[15:0];
            end
         end
      end
      res.ovf = ovf_flag;
      return 1'b1;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic func, input byte_type value,
                               input logic first, input bit typed,
                               input match_result_type typed_res);
      match_result_type res;
      req_bus.valid = 1'b1;
      req_bus.func = func;
      req_bus.byte_value = value;
      req_bus.first = first;
      forever begin
         #3;
         if (req_bus.ready) break;
         @(negedge clock);
      end
      @(posedge clock);
      if (rabin_karp_step(func, value, first, res))
         pending_results.insert(pending_results.size(), typed ? typed_res : res);
      request_count++;
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 55) n = 0;
      else if (n < 93) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 60);
      if (n > 0) begin
         req_bus.valid = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic send_random(input logic func, input byte_type value, input logic first);
      send_request(func, value, first, 1'b0, '{1'b0, 16'd0, 1'b0});
      sender_gap();
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // block must be idle; writes then reads back the base register
   task automatic write_hash_base(input logic [CSR_DATA_W-1:0] value);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = ADDR_HASH_BASE; csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_pwrite = 1'b0; csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      #3;
      if (csr_prdata != {3'b0, value[60:0]})
         report_mismatch($sformatf("hash_base read %h, wrote %h", csr_prdata, value));
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0;
      base_reg = value[60:0];
   endtask

   // response side: ready with random stalls, checked just before the edge
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_mode != 0 && $urandom_range(0, 99) < 30) begin
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(0, 2);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(negedge clock) begin
      match_result_type want;
      #3;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.found !== want.found)
               report_mismatch($sformatf("found %b, want %b", rsp_bus.found, want.found));
            if (rsp_bus.match_start !== want.start)
               report_mismatch($sformatf("match_start %0d, want %0d",
                                         rsp_bus.match_start, want.start));
            if (rsp_bus.overflow !== want.ovf)
               report_mismatch($sformatf("overflow %b, want %b",
                                         rsp_bus.overflow, want.ovf));
         end
      end
   end

   stim_row_type directed [] = '{
      // text with empty pattern never matches; a two-byte pattern then matches twice
      '{FUNC_TEXT,    8'h00, 1'b1, 1, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'hFF, 1'b0, 1, 1'b0, 16'd0, 1'b0},
      '{FUNC_PATTERN, 8'h00, 1'b1, 0, 1'b0, 16'd0, 1'b0},
      '{FUNC_PATTERN, 8'hFF, 1'b0, 0, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'h00, 1'b1, 1, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'hFF, 1'b0, 1, 1'b1, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'h00, 1'b0, 1, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'hFF, 1'b0, 1, 1'b1, 16'd2, 1'b0},
      '{FUNC_TEXT,    8'hFF, 1'b0, 0, 1'b0, 16'd0, 1'b0},
      // pattern byte mid-text extends the pattern and restarts the text
      '{FUNC_PATTERN, 8'h5A, 1'b0, 0, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'h00, 1'b0, 1, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'hFF, 1'b0, 1, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'h5A, 1'b0, 1, 1'b1, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'h00, 1'b0, 0, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'hFF, 1'b1, 0, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'h5A, 1'b0, 0, 1'b0, 16'd0, 1'b0},
      '{FUNC_PATTERN, 8'hA5, 1'b1, 0, 1'b0, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'hA5, 1'b1, 1, 1'b1, 16'd0, 1'b0},
      '{FUNC_TEXT,    8'hA5, 1'b0, 1, 1'b1, 16'd1, 1'b0},
      '{FUNC_TEXT,    8'h55, 1'b0, 0, 1'b0, 16'd0, 1'b0}
   };

   task automatic random_sequence();
      byte_type alpha [3];
      byte_type frag [$];
      int plen, tlen;
      for (int i = 0; i < 3; i++) alpha[i] = byte_type'($urandom);
      if ($urandom_range(0, 99) < 80) begin
         plen = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70)
                                             : $urandom_range(1, 6);
         frag.delete();
         for (int i = 0; i < plen; i++) begin
            frag.insert(frag.size(), alpha[$urandom_range(0, 2)]);
            send_random(FUNC_PATTERN, frag[i], i == 0);
         end
         tlen = $urandom_range(5, 40);
         for (int i = 0; i < tlen; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               foreach (frag[k]) send_random(FUNC_TEXT, frag[k], i == 0 && k == 0);
            end else begin
               send_random(FUNC_TEXT, alpha[$urandom_range(0, 2)],
                           (i == 0) || ($urandom_range(0, 49) == 0));
            end
         end
      end else begin
         repeat ($urandom_range(3, 15))
            send_random(logic'($urandom), byte_type'($urandom),
                        $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] bases [] = '{64'd2, {3'b0, MERSENNE_P - 61'd1},
                                          {3'b0, MERSENNE_P}, 64'd0, 64'd1,
                                          64'hFFFF_FFFF_FFFF_FFFF};
      int phase;
      reset = 1'b1;
      req_bus.valid = 1'b0; req_bus.func = 1'b0; req_bus.byte_value = '0;
      req_bus.first = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      clear_mirror();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         send_request(directed[i].func, directed[i].value, directed[i].first,
                      directed[i].typed,
                      '{directed[i].found, directed[i].start, directed[i].ovf});
         sender_gap();
      end
      drain();

      phase = 0;
      while (request_count < RANDOM_REQUESTS + $size(directed)) begin
         stall_mode = $urandom_range(0, 3) != 0;
         random_sequence();
         if (request_count / 120 != phase) begin
            phase = request_count / 120;
            drain();
            if (phase <= $size(bases))
               write_hash_base(bases[phase - 1]);
            else
               write_hash_base({$urandom, $urandom});
         end
      end
      drain();

      // pattern runs past its store, then a new pattern clears overflow
      stall_mode = 0;
      write_hash_base({3'b0, BASE_RESET});
      for (int i = 0; i < PAT_DEPTH + 2; i++)
         send_random(FUNC_PATTERN, 8'h61 + byte_type'(i % 2), i == 0);
      for (int i = 0; i < 20; i++)
         send_random(FUNC_TEXT, 8'h61 + byte_type'($urandom_range(0, 1)), i == 0);
      send_random(FUNC_PATTERN, 8'h61, 1'b1);
      send_random(FUNC_TEXT, 8'h61, 1'b1);
      drain();

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
